FILE: hdl/kps_pkg.sv
// ---------------------------------------------------------------------------
// kps_pkg
// Shared types, constants and helpers of the matrix keypad scanner core.
// ---------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

	localparam int ROWS       = 4;
	localparam int COLS       = 4;
	localparam int MAX_RES    = 4;
	localparam int NUM_KEYS   = ROWS * COLS;
	localparam int NUM_BANKS  = MAX_RES;
	localparam int BANK_DEPTH = NUM_KEYS / NUM_BANKS;

	localparam int CNT_W  = 3;
	localparam int ROW_W  = 2;
	localparam int KEY_W  = 4;
	localparam int LANE_W = 2;
	localparam int BADR_W = 2;
	localparam int TIME_W = 32;
	localparam int MS_W   = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	localparam logic [MS_W-1:0] SCAN_PERIOD_RST = 16'd50;
	localparam logic [MS_W-1:0] HOLD_TIME_RST   = 16'd2000;
	localparam logic [CNT_W-1:0] ROWS_RST = 3'd4;
	localparam logic [CNT_W-1:0] COLS_RST = 3'd4;

	localparam logic [3:0] DRIVE_IDLE = 4'hF;
	localparam logic [3:0] DRIVE_ROW0 = 4'hE;

	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS        = 8'd3;

	typedef enum logic [1:0] {
		KS_FREE     = 2'd0,
		KS_PRESSED  = 2'd1,
		KS_HOLD     = 2'd2,
		KS_RELEASED = 2'd3
	} key_state_t;

	typedef struct packed {
		key_state_t         st;
		logic               lvl;
		logic [TIME_W-1:0]  deadline;
	} key_rec_t;

	typedef struct packed {
		logic [3:0]       row_drive;
		logic             event_valid;
		logic [KEY_W-1:0] key_number;
		key_state_t       prior_state;
		key_state_t       next_state;
		logic             scan_changed;
		logic             last_of_run;
	} result_t;

	// 0 counts as 1, anything above hi saturates
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
	                                                 input logic [CNT_W-1:0] hi);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0)
			r = CNT_W'(1);
		else if (v > hi)
			r = hi;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/kps_key_bank.sv
// ---------------------------------------------------------------------------
// kps_key_bank
// One bank of key records (state, last level, hold deadline); keys whose
// index has the same two low bits share a bank.
// ---------------------------------------------------------------------------
`default_nettype none

module kps_key_bank (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [kps_pkg::BADR_W-1:0] rd_addr,
	output kps_pkg::key_rec_t               rd_data,
	input  wire logic                       wr_en,
	input  wire logic [kps_pkg::BADR_W-1:0] wr_addr,
	input  kps_pkg::key_rec_t               wr_data
);
	import kps_pkg::*;

	key_rec_t rec_q [BANK_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_DEPTH; i++) begin
				rec_q[i].st       <= KS_FREE;
				rec_q[i].lvl      <= 1'b1;
				rec_q[i].deadline <= '0;
			end
		end else if (wr_en) begin
			rec_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rec_q[rd_addr];

endmodule

`default_nettype wire

FILE: hdl/kps_key_fsm.sv
// ---------------------------------------------------------------------------
// kps_key_fsm
// Next-state logic of one key: free, pressed, hold, released.
// ---------------------------------------------------------------------------
`default_nettype none

module kps_key_fsm (
	input  kps_pkg::key_rec_t                cur,
	input  wire logic                        level,
	input  wire logic [kps_pkg::TIME_W-1:0]  now,
	input  wire logic [kps_pkg::MS_W-1:0]    hold_time,
	output kps_pkg::key_rec_t                nxt,
	output logic                             changed
);
	import kps_pkg::*;

	logic              same;
	logic [TIME_W-1:0] since;
	logic              past_due;
	key_state_t        ns;

	assign same     = (cur.lvl == level);
	assign since    = now - cur.deadline;
	// wrap-safe: difference positive as a signed value
	assign past_due = (since != '0) && !since[TIME_W-1];

	always_comb begin
		ns = cur.st;
		unique case (cur.st)
			KS_FREE:     ns = same ? KS_FREE : KS_PRESSED;
			KS_PRESSED:  ns = !same ? KS_RELEASED : (past_due ? KS_HOLD : KS_PRESSED);
			KS_HOLD:     ns = same ? KS_HOLD : KS_RELEASED;
			KS_RELEASED: ns = same ? KS_FREE : KS_PRESSED;
			default:     ns = KS_FREE;
		endcase
	end

	always_comb begin
		nxt.st       = ns;
		nxt.lvl      = level;
		nxt.deadline = cur.deadline;
		if (ns == KS_PRESSED && cur.st != KS_PRESSED)
			nxt.deadline = now + {{(TIME_W-MS_W){1'b0}}, hold_time};
	end

	assign changed = (ns != cur.st);

endmodule

`default_nettype wire

FILE: hdl/kps_out_buf.sv
// ---------------------------------------------------------------------------
// kps_out_buf
// Result buffer: loads all results of one tick at once and hands them out
// one transaction per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module kps_out_buf (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic [kps_pkg::CNT_W-1:0] load_cnt,
	input  kps_pkg::result_t               load_res [kps_pkg::MAX_RES],
	output logic                           load_ok,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output kps_pkg::result_t               out_res
);
	import kps_pkg::*;

	result_t           ent_q [MAX_RES];
	logic [CNT_W-1:0]  cnt_q;
	logic [LANE_W-1:0] ptr_q;
	logic              fire;

	assign out_valid = (cnt_q != '0);
	assign fire      = out_valid && out_ready;
	assign load_ok   = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_ready);
	assign out_res   = ent_q[ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
			ptr_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
			ptr_q <= ptr_q + LANE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ent_q <= load_res;
	end

endmodule

`default_nettype wire

FILE: hdl/matrix_keypad_scanner_core.sv
// ---------------------------------------------------------------------------
// matrix_keypad_scanner_core
// Matrix keypad scanner with per-key press, hold and release detection.
// ---------------------------------------------------------------------------
// Each input transaction is one millisecond tick carrying the active-low
// column levels of the row driven low after the previous tick. A tick is
// taken into an input register and processed against the key records, which
// sit in four banks so that the up to four keys of a row are read and updated
// together. Its results go to a buffer that emits one transaction per cycle
// while the output is ready: a scanned row gives cols_in_use results (1 to 4),
// any other tick one empty result. The output port sets the rate; a new tick
// waits in the input register while the buffer drains and is processed as the
// last result leaves. Key records reset directly; there is no clearing pass.
`default_nettype none

module matrix_keypad_scanner_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [kps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kps_pkg::CFG_DAT_W-1:0] cfg_data,
	// ticks in
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [3:0] col_levels
	// results out
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [3:0] row_drive, [4] event_valid, [8:5] key_number, [10:9] prior_state,
	// [12:11] next_state, [13] scan_changed, [15:14] zero
	output logic [15:0]                        m_axis_tdata,
	output logic                               m_axis_tlast   // last_of_run
);
	import kps_pkg::*;

	// configuration
	logic [MS_W-1:0]   scan_period_q;
	logic [MS_W-1:0]   hold_time_q;
	logic [CNT_W-1:0]  rows_q;
	logic [CNT_W-1:0]  cols_q;

	// scan state
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] last_scan_q;
	logic [ROW_W-1:0]  row_q;
	logic              scan_active_q;
	logic              change_seen_q;

	// input register
	logic              valid_s1;
	logic [3:0]        levels_s1;

	logic              in_fire;
	logic              proceed;
	logic              buf_ok;

	logic [CNT_W-1:0]  re;
	logic [CNT_W-1:0]  ce;
	logic              scan_start;
	logic              row_done;
	logic              do_row;
	logic [CNT_W-1:0]  row_next;
	logic [KEY_W-1:0]  base;
	logic [3:0]        drive_row;

	key_rec_t          rd_rec  [NUM_BANKS];
	key_rec_t          new_rec [NUM_BANKS];
	logic              bank_ev [NUM_BANKS];
	logic [LANE_W-1:0] bank_lane [NUM_BANKS];
	logic [KEY_W-1:0]  bank_idx  [NUM_BANKS];
	logic              bank_we   [NUM_BANKS];

	result_t           res     [MAX_RES];
	logic [CNT_W-1:0]  res_cnt;
	logic              any_ev;
	result_t           out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RST;
			hold_time_q   <= HOLD_TIME_RST;
			rows_q        <= ROWS_RST;
			cols_q        <= COLS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCAN_PERIOD: scan_period_q <= cfg_data;
				CFG_HOLD_TIME:   hold_time_q   <= cfg_data;
				CFG_ROWS:        rows_q        <= cfg_data[CNT_W-1:0];
				CFG_COLS:        cols_q        <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign proceed       = valid_s1 && buf_ok;
	assign s_axis_tready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (proceed)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			levels_s1 <= s_axis_tdata[3:0];
	end

	// scan control
	assign re         = clamp_count(rows_q, CNT_W'(ROWS));
	assign ce         = clamp_count(clamp_count(cols_q, CNT_W'(COLS)), CNT_W'(MAX_RES));
	assign scan_start = !scan_active_q &&
	                    ((now_q - last_scan_q) >= {{(TIME_W-MS_W){1'b0}}, scan_period_q});
	assign do_row     = scan_active_q && ({1'b0, row_q} < re);
	assign row_next   = {1'b0, row_q} + CNT_W'(1);
	assign row_done   = scan_active_q && (row_next >= re);
	assign base       = KEY_W'(row_q) * KEY_W'(ce);
	assign drive_row  = row_done ? DRIVE_IDLE : ~(4'b0001 << row_next[ROW_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_scan_q   <= '0;
			row_q         <= '0;
			scan_active_q <= 1'b0;
			change_seen_q <= 1'b0;
		end else if (proceed) begin
			now_q <= now_q + TIME_W'(1);
			if (!scan_active_q) begin
				if (scan_start) begin
					scan_active_q <= 1'b1;
					row_q         <= '0;
					change_seen_q <= 1'b0;
				end
			end else if (row_done) begin
				// also covers a row count shrunk below the current row
				scan_active_q <= 1'b0;
				last_scan_q   <= now_q;
				row_q         <= '0;
				if (do_row && any_ev)
					change_seen_q <= 1'b1;
			end else begin
				row_q <= row_next[ROW_W-1:0];
				if (any_ev)
					change_seen_q <= 1'b1;
			end
		end
	end

	// key banks: the keys of one row are consecutive, so each hits its own bank
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		assign bank_lane[b] = LANE_W'(b) - base[LANE_W-1:0];
		assign bank_idx[b]  = base + KEY_W'(bank_lane[b]);
		assign bank_we[b]   = proceed && do_row && ({1'b0, bank_lane[b]} < ce);

		kps_key_bank u_bank (
			.clk     (clk),
			.arst_n  (arst_n),
			.rd_addr (bank_idx[b][KEY_W-1:LANE_W]),
			.rd_data (rd_rec[b]),
			.wr_en   (bank_we[b]),
			.wr_addr (bank_idx[b][KEY_W-1:LANE_W]),
			.wr_data (new_rec[b])
		);

		kps_key_fsm u_fsm (
			.cur       (rd_rec[b]),
			.level     (levels_s1[bank_lane[b]]),
			.now       (now_q),
			.hold_time (hold_time_q),
			.nxt       (new_rec[b]),
			.changed   (bank_ev[b])
		);
	end

	// gather per-column results in column order
	always_comb begin
		logic [LANE_W-1:0] sel;
		logic              acc;
		acc    = change_seen_q;
		any_ev = 1'b0;
		for (int j = 0; j < MAX_RES; j++) begin
			sel = base[LANE_W-1:0] + LANE_W'(j);
			if (do_row) begin
				if (CNT_W'(j) < ce) begin
					acc    = acc | bank_ev[sel];
					any_ev = any_ev | bank_ev[sel];
				end
				res[j].row_drive    = drive_row;
				res[j].event_valid  = bank_ev[sel];
				res[j].key_number   = bank_idx[sel];
				res[j].prior_state  = rd_rec[sel].st;
				res[j].next_state   = new_rec[sel].st;
				res[j].scan_changed = acc;
				res[j].last_of_run  = (CNT_W'(j + 1) == ce);
			end else begin
				res[j].row_drive    = (scan_start) ? DRIVE_ROW0 : DRIVE_IDLE;
				res[j].event_valid  = 1'b0;
				res[j].key_number   = '0;
				res[j].prior_state  = KS_FREE;
				res[j].next_state   = KS_FREE;
				res[j].scan_changed = scan_start ? 1'b0 : change_seen_q;
				res[j].last_of_run  = 1'b1;
			end
		end
		res_cnt = do_row ? ce : CNT_W'(1);
	end

	kps_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (proceed),
		.load_cnt  (res_cnt),
		.load_res  (res),
		.load_ok   (buf_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.scan_changed, out_res.next_state,
	                       out_res.prior_state, out_res.key_number,
	                       out_res.event_valid, out_res.row_drive};
	assign m_axis_tlast = out_res.last_of_run;

	// a processed tick always leaves something to send
	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		proceed |=> m_axis_tvalid)
		else $error("processed tick left no result");

	// a run is not cut short before its last transaction
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("result run broken before last");

	// the row pointer parks at zero while no scan is running
	a_idle_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_active_q |-> (row_q == '0))
		else $error("row pointer not parked while idle");

	// time only moves when a tick is processed
	a_now_steps: assert property (@(posedge clk) disable iff (!arst_n)
		!proceed |=> $stable(now_q))
		else $error("tick counter moved without a tick");

endmodule

`default_nettype wire
